// File: hw/rtl/selective_ack_report_builder_defines.svh
// ----------------------------------------------------------------------------
// Selective ack report builder assertion macros
// Shared concurrent assertion forms, clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_ACK_REPORT_BUILDER_DEFINES_SVH
`define SELECTIVE_ACK_REPORT_BUILDER_DEFINES_SVH

// Same-cycle implication.
`define SARB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SARB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/sarb_pkg.sv
// ----------------------------------------------------------------------------
// sarb_pkg
// Types and constants shared by the selective ack report builder.
// ----------------------------------------------------------------------------
package sarb_pkg;

    localparam int TOTAL_W      = 10;
    localparam int ID_W         = 32;
    localparam int CHUNK_W      = 16;
    localparam int WORD_W       = 64;
    localparam int WORD_SH      = 6;
    localparam int SCAN_BITS    = 8;
    localparam int SCAN_SH      = 3;
    localparam int GRP_W        = TOTAL_W - SCAN_SH;
    localparam int REPORT_WORDS = 8;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;

    // bitmap size and gap record slots
    localparam int CHUNK_LIMIT  = 512;
    localparam int GAP_LIMIT    = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID    = 1'b1;

    typedef enum logic [1:0] {
        CMD_MARK   = 2'd0,
        CMD_REPORT = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_GAP    = 2'd1,
        KIND_WORD   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        MSG_COMPLETE = 2'd0,
        MSG_NACK     = 2'd1,
        MSG_ACK      = 2'd2
    } t_msg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MARK_WR,
        S_SCAN_RD,
        S_SCAN_STEP,
        S_SCAN_CLOSE,
        S_EMIT_HDR,
        S_EMIT_GAP,
        S_WORD_RD,
        S_EMIT_WORD
    } t_state;

    typedef struct packed {
        logic [1:0]         command;
        logic [ID_W-1:0]    message_id;
        logic [CHUNK_W-1:0] chunk_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        record_kind;
        logic [1:0]        message_type;
        logic [8:0]        cumulative_chunk;
        logic [2:0]        gap_count;
        logic [3:0]        num_words;
        logic [8:0]        gap_first;
        logic [9:0]        gap_length;
        logic [2:0]        word_index;
        logic [WORD_W-1:0] bitmap_word;
        logic              last_of_run;
    } t_out_item;

    typedef struct packed {
        logic load_in;
        logic clear_bits;
        logic scan_init;
        logic mark_rd;
        logic mark_wr;
        logic scan_rd;
        logic scan_step;
        logic scan_close;
        logic emit_hdr;
        logic emit_gap;
        logic word_rd;
        logic emit_word;
    } t_dp_cmd;

    typedef struct packed {
        logic mark_hit;
        logic is_report;
        logic is_clear;
        logic total_zero;
        logic in_range;
        logic sub_last;
        logic scan_end;
        logic out_free;
        logic no_gaps;
        logic gap_last;
        logic no_words;
        logic word_last;
    } t_dp_stat;

endpackage

// File: hw/rtl/sarb_ram.sv
// ----------------------------------------------------------------------------
// sarb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sarb_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/sarb_ctrl.sv
// ----------------------------------------------------------------------------
// sarb_ctrl
// Sequencer: decode, mark read-modify-write, bitmap scan, record emission.
// ----------------------------------------------------------------------------
module sarb_ctrl
    import sarb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.is_clear) begin
                    o_cmd.clear_bits = 1'b1;
                    n_state          = S_IDLE;
                end else if ((i_stat.mark_hit || i_stat.is_report) && !i_stat.total_zero) begin
                    o_cmd.scan_init = 1'b1;
                    if (i_stat.mark_hit && i_stat.in_range) begin
                        o_cmd.mark_rd = 1'b1;
                        n_state       = S_MARK_WR;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MARK_WR: begin
                o_cmd.mark_wr = 1'b1;
                n_state       = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_SCAN_STEP;
            end
            S_SCAN_STEP: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_end) begin
                    n_state = S_SCAN_CLOSE;
                end else if (i_stat.sub_last) begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_CLOSE: begin
                o_cmd.scan_close = 1'b1;
                n_state          = S_EMIT_HDR;
            end
            S_EMIT_HDR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_hdr = 1'b1;
                    if (!i_stat.no_gaps) begin
                        n_state = S_EMIT_GAP;
                    end else if (!i_stat.no_words) begin
                        n_state = S_WORD_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT_GAP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_gap = 1'b1;
                    if (i_stat.gap_last) begin
                        n_state = i_stat.no_words ? S_IDLE : S_WORD_RD;
                    end
                end
            end
            S_WORD_RD: begin
                o_cmd.word_rd = 1'b1;
                n_state       = S_EMIT_WORD;
            end
            S_EMIT_WORD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_word = 1'b1;
                    n_state         = i_stat.word_last ? S_IDLE : S_WORD_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/sarb_dp.sv
// ----------------------------------------------------------------------------
// sarb_dp
// Datapath: config registers, bitmap RAM with row valid bits, scan unit,
// gap registers and the output record register.
// ----------------------------------------------------------------------------
module sarb_dp
    import sarb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_in_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output t_out_item             o_out_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat
);

    localparam int STORE_WORDS = (CHUNK_LIMIT + WORD_W - 1) / WORD_W;
    localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int NGW         = $clog2(GAP_LIMIT + 1);
    localparam int GIW         = (GAP_LIMIT > 1) ? $clog2(GAP_LIMIT) : 1;
    localparam int CAP         = (CHUNK_LIMIT < 1023) ? CHUNK_LIMIT : 1023;

    // configuration
    logic [TOTAL_W-1:0] r_total;
    logic [ID_W-1:0]    r_exp_id;
    logic [TOTAL_W-1:0] eff_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_exp_id <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_TOTAL) begin
                r_total <= i_cfg_data[TOTAL_W-1:0];
            end else begin
                r_exp_id <= i_cfg_data[ID_W-1:0];
            end
        end
    end

    assign eff_total = (r_total > TOTAL_W'(CAP)) ? TOTAL_W'(CAP) : r_total;

    // latched transaction
    t_in_item r_in;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_data;
        end
    end

    // bitmap storage
    logic [STORE_WORDS-1:0] r_row_valid;
    logic                   r_rd_valid;
    logic [AW-1:0]          raddr;
    logic                   re;
    logic [AW-1:0]          mark_addr;
    logic [WORD_W-1:0]      rdata;
    logic [WORD_W-1:0]      rword;
    logic [WORD_W-1:0]      mark_word;
    logic [GRP_W-1:0]       r_grp;
    logic [2:0]             r_wi;

    assign mark_addr = AW'(r_in.chunk_index[CHUNK_W-1:WORD_SH]);
    assign re        = i_cmd.mark_rd | i_cmd.scan_rd | i_cmd.word_rd;

    always_comb begin
        priority if (i_cmd.mark_rd) begin
            raddr = mark_addr;
        end else if (i_cmd.scan_rd) begin
            raddr = AW'(r_grp[GRP_W-1:WORD_SH-SCAN_SH]);
        end else begin
            raddr = AW'(r_wi);
        end
    end

    sarb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_bits (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mark_wr),
        .i_waddr (mark_addr),
        .i_wdata (mark_word),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (i_cmd.clear_bits) begin
            r_row_valid <= '0;
        end else if (i_cmd.mark_wr) begin
            r_row_valid[mark_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (re) begin
            r_rd_valid <= r_row_valid[raddr];
        end
    end

    // rows never written read as zero
    assign rword     = rdata & {WORD_W{r_rd_valid}};
    assign mark_word = rword | (WORD_W'(1) << r_in.chunk_index[WORD_SH-1:0]);

    // scan unit: eight chunk positions per step
    logic                r_lead, n_lead;
    logic [TOTAL_W-1:0]  r_lcount, n_lcount;
    logic                r_all, n_all;
    logic                r_ing, n_ing;
    logic [TOTAL_W-1:0]  r_rs, n_rs;
    logic [TOTAL_W-1:0]  r_rl, n_rl;
    logic [NGW-1:0]      r_ng, n_ng;
    logic [TOTAL_W-1:0]  r_gs [GAP_LIMIT];
    logic [TOTAL_W-1:0]  n_gs [GAP_LIMIT];
    logic [TOTAL_W-1:0]  r_gl [GAP_LIMIT];
    logic [TOTAL_W-1:0]  n_gl [GAP_LIMIT];
    logic [SCAN_BITS-1:0] scan_bits;
    logic [TOTAL_W-1:0]  pos;

    assign scan_bits = rword[{r_grp[WORD_SH-SCAN_SH-1:0], SCAN_SH'(0)} +: SCAN_BITS];

    always_comb begin
        n_lead   = r_lead;
        n_lcount = r_lcount;
        n_all    = r_all;
        n_ing    = r_ing;
        n_rs     = r_rs;
        n_rl     = r_rl;
        n_ng     = r_ng;
        n_gs     = r_gs;
        n_gl     = r_gl;
        pos      = '0;
        for (int i = 0; i < SCAN_BITS; i++) begin
            pos = {r_grp, SCAN_SH'(i)};
            if (pos < eff_total) begin
                if (!scan_bits[i]) begin
                    n_all  = 1'b0;
                    n_lead = 1'b0;
                end else if (n_lead) begin
                    n_lcount = n_lcount + 1'b1;
                end
                // chunk 0 never opens a gap
                if (pos != '0) begin
                    if (!scan_bits[i]) begin
                        if (n_ing) begin
                            n_rl = n_rl + 1'b1;
                        end else if (n_ng < NGW'(GAP_LIMIT)) begin
                            n_ing = 1'b1;
                            n_rs  = pos;
                            n_rl  = TOTAL_W'(1);
                        end
                    end else if (n_ing) begin
                        n_gs[n_ng[GIW-1:0]] = n_rs;
                        n_gl[n_ng[GIW-1:0]] = n_rl;
                        n_ng                = n_ng + 1'b1;
                        n_ing               = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_lead   <= 1'b1;
            r_lcount <= '0;
            r_all    <= 1'b1;
            r_ing    <= 1'b0;
            r_rs     <= '0;
            r_rl     <= '0;
            r_ng     <= '0;
            r_grp    <= '0;
        end else if (i_cmd.scan_step) begin
            r_lead   <= n_lead;
            r_lcount <= n_lcount;
            r_all    <= n_all;
            r_ing    <= n_ing;
            r_rs     <= n_rs;
            r_rl     <= n_rl;
            r_ng     <= n_ng;
            r_gs     <= n_gs;
            r_gl     <= n_gl;
            r_grp    <= r_grp + 1'b1;
        end else if (i_cmd.scan_close && r_ing) begin
            // run still open at the total
            r_gs[r_ng[GIW-1:0]] <= r_rs;
            r_gl[r_ng[GIW-1:0]] <= r_rl;
            r_ng                <= r_ng + 1'b1;
            r_ing               <= 1'b0;
        end
    end

    // report fields
    logic [4:0]         nw_raw;
    logic [3:0]         nw;
    logic [TOTAL_W-1:0] cum;
    logic [GIW-1:0]     r_gi;
    logic [TOTAL_W:0]   tail;
    logic [WORD_W-1:0]  tail_mask;
    logic               gap_last;
    logic               word_last;

    assign nw_raw    = 5'(({1'b0, eff_total} + (TOTAL_W+1)'(WORD_W - 1)) >> WORD_SH);
    assign nw        = (nw_raw > 5'(REPORT_WORDS)) ? 4'(REPORT_WORDS) : nw_raw[3:0];
    assign cum       = (r_lcount != '0) ? r_lcount - 1'b1 : '0;
    assign gap_last  = (NGW'(r_gi) + NGW'(1)) == r_ng;
    assign word_last = ({1'b0, r_wi} + 4'd1) == nw;
    assign tail      = {1'b0, eff_total} - (TOTAL_W+1)'({r_wi, WORD_SH'(0)});
    assign tail_mask = (tail >= (TOTAL_W+1)'(WORD_W)) ? {WORD_W{1'b1}}
                     : ~({WORD_W{1'b1}} << tail[WORD_SH-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_hdr) begin
            r_gi <= '0;
            r_wi <= '0;
        end else begin
            if (i_cmd.emit_gap) begin
                r_gi <= r_gi + 1'b1;
            end
            if (i_cmd.emit_word) begin
                r_wi <= r_wi + 1'b1;
            end
        end
    end

    // output record register
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    always_comb begin
        n_out = '0;
        priority if (i_cmd.emit_hdr) begin
            n_out.record_kind      = KIND_HEADER;
            n_out.message_type     = r_all ? MSG_COMPLETE
                                   : ((r_ng != '0) ? MSG_NACK : MSG_ACK);
            n_out.cumulative_chunk = cum[8:0];
            n_out.gap_count        = 3'(r_ng);
            n_out.num_words        = nw;
            n_out.last_of_run      = (r_ng == '0) && (nw == '0);
        end else if (i_cmd.emit_gap) begin
            n_out.record_kind = KIND_GAP;
            n_out.gap_first   = r_gs[r_gi][8:0];
            n_out.gap_length  = r_gl[r_gi];
            n_out.last_of_run = gap_last && (nw == '0);
        end else begin
            n_out.record_kind = KIND_WORD;
            n_out.word_index  = r_wi;
            n_out.bitmap_word = rword & tail_mask;
            n_out.last_of_run = word_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_hdr || i_cmd.emit_gap || i_cmd.emit_word) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_hdr || i_cmd.emit_gap || i_cmd.emit_word) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // status to the sequencer
    assign o_stat.mark_hit   = (r_in.command == CMD_MARK) && (r_in.message_id == r_exp_id);
    assign o_stat.is_report  = r_in.command == CMD_REPORT;
    assign o_stat.is_clear   = r_in.command == CMD_CLEAR;
    assign o_stat.total_zero = eff_total == '0;
    assign o_stat.in_range   = r_in.chunk_index < CHUNK_W'(eff_total);
    assign o_stat.sub_last   = &r_grp[WORD_SH-SCAN_SH-1:0];
    assign o_stat.scan_end   = ({1'b0, r_grp, SCAN_SH'(0)} + (TOTAL_W+1)'(SCAN_BITS))
                             >= {1'b0, eff_total};
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_stat.no_gaps    = r_ng == '0;
    assign o_stat.gap_last   = gap_last;
    assign o_stat.no_words   = nw == '0;
    assign o_stat.word_last  = word_last;

endmodule

// File: hw/rtl/selective_ack_report_builder.sv
// ----------------------------------------------------------------------------
// selective_ack_report_builder
// Selective-repeat acknowledgement report builder, top level.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid/o_in_ready/i_in_data) takes one command per
// transaction: mark a chunk done and report, report only, or clear the
// bitmap. Marks whose message id differs from the configured id are dropped.
// Output channel (o_out_valid/i_out_ready/o_out_data) carries one record per
// transaction: a header, up to four gap records, then up to eight bitmap
// words; last_of_run flags the final record of a report.
// Config port: i_cfg_we with i_cfg_index 0 (total chunks) or 1 (message id);
// the user must write it only while the block is idle; the block does not enforce this.
// Sequence: one command at a time. Decode comes first, a mark adds the
// read-modify-write of its row, and the scan reads each 64-bit bitmap
// row and steps through it eight chunks per step; a close state and the
// header load follow. Gap records come from the gap registers; each
// bitmap word is read from the RAM before it is loaded.
// Reset clears the bitmap (row valid bits), config registers and output.
// A receiver stall holds the output register and freezes the sequencer;
// no record is dropped, and input waits until the last record is loaded.
// ----------------------------------------------------------------------------
`include "selective_ack_report_builder_defines.svh"

module selective_ack_report_builder
    import sarb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer
    sarb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // storage, scan and record formatting
    sarb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat)
    );

    logic emit_any;
    logic hdr_out;
    logic in_fire;

    assign emit_any = dp_cmd.emit_hdr || dp_cmd.emit_gap || dp_cmd.emit_word;
    assign hdr_out  = o_out_valid && (o_out_data.record_kind == KIND_HEADER);
    assign in_fire  = i_in_valid && o_in_ready;

    // A record only loads when the output register can take it.
    `SARB_ASSERT_IMPL(a_emit_free, emit_any, dp_stat.out_free, "record loaded while busy")
    // The bitmap write of a mark always follows its row read.
    `SARB_ASSERT_IMPL(a_mark_rmw, dp_cmd.mark_wr, $past(dp_cmd.mark_rd), "mark write, no read")
    // No report is built with an empty total, so headers always carry words.
    `SARB_ASSERT_IMPL(a_hdr_words, hdr_out, o_out_data.num_words != '0, "header without words")
    // Taking a command drops input ready and starts decode, not a scan step.
    `SARB_ASSERT_NEXT(a_accept, in_fire, !dp_cmd.scan_step && !o_in_ready, "accept while busy")

endmodule
